// ===== rtl/irqz_pkg.sv =====
// shared types, widths and state codes of the implicit rating quantizer
package irqz_pkg;

  localparam int unsigned PersonW  = 31;
  localparam int unsigned ElementW = 32;
  localparam int unsigned RatingW  = 6;

  typedef enum logic [4:0] {
    ST_COUNT = 5'b00001,
    ST_READ  = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

endpackage

// ===== rtl/irqz_evt_if.sv =====
// event channel: person, element and last-event flag
interface irqz_evt_if;
  logic                           valid;
  logic                           ready;
  logic [irqz_pkg::PersonW-1:0]   person_id;
  logic [irqz_pkg::ElementW-1:0]  element_id;
  logic                           group_last;

  modport source (output valid, person_id, element_id, group_last, input ready);
  modport sink   (input valid, person_id, element_id, group_last, output ready);
endinterface

// ===== rtl/irqz_rat_if.sv =====
// rating channel: one rated element per transaction
interface irqz_rat_if;
  logic                           valid;
  logic                           ready;
  logic [irqz_pkg::PersonW-1:0]   person_id_out;
  logic [irqz_pkg::ElementW-1:0]  element_id_out;
  logic [irqz_pkg::RatingW-1:0]   rating;
  logic                           overflow;
  logic                           last_of_group;

  modport source (output valid, person_id_out, element_id_out, rating, overflow,
                  last_of_group, input ready);
  modport sink   (input valid, person_id_out, element_id_out, rating, overflow,
                  last_of_group, output ready);
endinterface

// ===== rtl/implicit_rating_quantizer.sv =====
// top level: run counter, entry store and iterative band divider
// Events are taken one per cycle while a person's group is being counted; runs of equal
// element ids go into a store of MAX_DISTINCT entries (one write per stored event) and the largest
// run count is tracked. The flagged last event of a group stops intake: the block then reads
// the store back one entry at a time and divides RATING_BANDS*count by the largest count
// with a shared restoring divider that settles one quotient bit per cycle. Each rating passes
// through the read, load, divide and output states, the last of which waits on the rating
// channel, and intake resumes the cycle after the group's last rating is taken. Counts
// saturate at 2^COUNT_BITS-1; elements beyond the store size are dropped and flagged as
// overflow on every rating of that group. The store needs no clearing after reset.
module implicit_rating_quantizer #(
  parameter int unsigned MAX_DISTINCT = 64,
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned RATING_BANDS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  irqz_evt_if.sink   evt_i,
  irqz_rat_if.source rat_o
);

  localparam int unsigned IW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
  localparam int unsigned UW = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned QB = $clog2(RATING_BANDS + 1);
  localparam int unsigned SW = $clog2(QB);
  localparam int unsigned NW = COUNT_BITS + QB;
  localparam int unsigned EW = irqz_pkg::ElementW;
  localparam int unsigned MW = EW + COUNT_BITS;

  irqz_pkg::state_e state_q, state_d;

  logic [UW-1:0]                   used_q, used_d;
  logic [COUNT_BITS-1:0]           largest_q, largest_d;
  logic [COUNT_BITS-1:0]           cur_cnt_q, cur_cnt_d;
  logic [EW-1:0]                   cur_elem_q, cur_elem_d;
  logic [irqz_pkg::PersonW-1:0]    person_q, person_d;
  logic                            ovf_q, ovf_d;
  logic [IW-1:0]                   idx_q, idx_d;
  logic [NW-1:0]                   rem_q, rem_d;
  logic [NW-1:0]                   div_q, div_d;
  logic [QB-1:0]                   quo_q, quo_d;
  logic [SW-1:0]                   step_q, step_d;
  logic [QB-1:0]                   band_q, band_d;

  logic [MW-1:0]                   store_q [MAX_DISTINCT];
  logic [EW-1:0]                   rd_elem_q;
  logic [COUNT_BITS-1:0]           rd_cnt_q;
  logic                            rd_en;

  logic                            evt_acc, rat_acc, last_entry;
  logic                            match, opening;
  logic [COUNT_BITS-1:0]           base_cnt;
  logic                            wr_en;
  logic [IW-1:0]                   wr_idx;
  logic [NW-1:0]                   trial;
  logic                            fits;
  logic [QB-1:0]                   quo_next, band_raw;

  assign evt_acc    = evt_i.valid && evt_i.ready;
  assign rat_acc    = rat_o.valid && rat_o.ready;
  assign last_entry = (UW'(idx_q) + UW'(1)) == used_q;

  assign evt_i.ready          = (state_q == irqz_pkg::ST_COUNT);
  assign rat_o.valid          = (state_q == irqz_pkg::ST_OUT);
  assign rat_o.person_id_out  = person_q;
  assign rat_o.element_id_out = rd_elem_q;
  assign rat_o.rating         = irqz_pkg::RatingW'(band_q);
  assign rat_o.overflow       = ovf_q;
  assign rat_o.last_of_group  = last_entry;

  // run counting of one event
  always_comb begin
    opening  = 1'b0;
    match    = 1'b1;
    used_d   = used_q;
    ovf_d    = ovf_q;
    person_d = person_q;
    base_cnt = cur_cnt_q;
    if (used_q == '0) begin
      opening  = 1'b1;
      used_d   = UW'(1);
      person_d = evt_i.person_id;
    end else if (cur_elem_q != evt_i.element_id) begin
      if (used_q < UW'(MAX_DISTINCT)) begin
        opening = 1'b1;
        used_d  = used_q + UW'(1);
      end else begin
        match = 1'b0;
        ovf_d = 1'b1;
      end
    end
    if (opening) begin
      base_cnt = '0;
    end
    cur_elem_d = opening ? evt_i.element_id : cur_elem_q;
    cur_cnt_d  = cur_cnt_q;
    largest_d  = largest_q;
    if (match) begin
      cur_cnt_d = (&base_cnt) ? base_cnt : base_cnt + COUNT_BITS'(1);
      if (cur_cnt_d > largest_q) begin
        largest_d = cur_cnt_d;
      end
    end
    wr_en  = evt_acc && match;
    wr_idx = IW'(used_d - UW'(1));
  end

  // divider step
  assign fits     = rem_q >= div_q;
  assign trial    = rem_q - div_q;
  assign quo_next = {quo_q[QB-2:0], fits};
  assign band_raw = quo_next + QB'(1);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    step_d  = step_q;
    band_d  = band_q;
    rd_en   = 1'b0;
    unique case (state_q)
      irqz_pkg::ST_COUNT: begin
        if (evt_acc && evt_i.group_last) begin
          idx_d   = '0;
          state_d = irqz_pkg::ST_READ;
        end
      end
      irqz_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = irqz_pkg::ST_LOAD;
      end
      irqz_pkg::ST_LOAD: begin
        rem_d   = NW'(rd_cnt_q) * NW'(RATING_BANDS);
        div_d   = NW'(largest_q) << (QB - 1);
        quo_d   = '0;
        step_d  = SW'(QB - 1);
        state_d = irqz_pkg::ST_DIV;
      end
      irqz_pkg::ST_DIV: begin
        if (fits) begin
          rem_d = trial;
        end
        div_d  = div_q >> 1;
        quo_d  = quo_next;
        step_d = step_q - SW'(1);
        if (step_q == '0) begin
          band_d  = (quo_next >= QB'(RATING_BANDS)) ? QB'(RATING_BANDS) : band_raw;
          state_d = irqz_pkg::ST_OUT;
        end
      end
      irqz_pkg::ST_OUT: begin
        if (rat_acc) begin
          idx_d   = idx_q + IW'(1);
          state_d = last_entry ? irqz_pkg::ST_COUNT : irqz_pkg::ST_READ;
        end
      end
      default: state_d = irqz_pkg::ST_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= irqz_pkg::ST_COUNT;
      used_q    <= '0;
      largest_q <= '0;
      person_q  <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      if (evt_acc) begin
        used_q    <= used_d;
        largest_q <= largest_d;
        person_q  <= person_d;
        ovf_q     <= ovf_d;
      end else if (rat_acc && last_entry) begin
        used_q    <= '0;
        largest_q <= '0;
        ovf_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      cur_elem_q <= cur_elem_d;
      cur_cnt_q  <= cur_cnt_d;
    end
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    band_q <= band_d;
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= {cur_elem_d, cur_cnt_d};
    end
    if (rd_en) begin
      {rd_elem_q, rd_cnt_q} <= store_q[idx_q];
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.ready |-> !rat_o.valid)
    else $error("intake open while a rating is pending");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_DISTINCT))
    else $error("store fill beyond its size");

  a_group_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rat_acc && rat_o.last_of_group) |=> (used_q == '0 && largest_q == '0 && !ovf_q))
    else $error("group not cleared after its last rating");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rat_o.valid |-> (band_q != '0 && band_q <= QB'(RATING_BANDS)))
    else $error("rating out of band range");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_acc && evt_i.group_last) |=> (used_q != '0 && largest_q != '0))
    else $error("emission started on an empty group");
`endif

endmodule
